FILE: rtl/core/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted record table
// Sizes, record layout, operation and status codes used by the cell row and
// the control logic.
// ----------------------------------------------------------------------------
package srt_pkg;

	// table size and derived widths
	localparam int CAPACITY  = 64;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// field widths
	localparam int KEY_W     = 32;
	localparam int NAME0_W   = 64;
	localparam int NAME1_W   = 64;
	localparam int NAME2_W   = 32;
	localparam int STATUS_W  = 3;
	localparam int ECOUNT_W  = 7;
	localparam int S_TDATA_W = KEY_W + NAME0_W + NAME1_W + NAME2_W;
	localparam int M_TDATA_W = 16;

	// operation carried in tuser
	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_DELETE = 1'b1
	} func_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_INSERTED = 3'd0,
		STATUS_DELETED  = 3'd1,
		STATUS_NOMATCH  = 3'd2,
		STATUS_EMPTY    = 3'd3,
		STATUS_FULL     = 3'd4
	} status_t;

	// one stored record
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [NAME0_W-1:0] name0;
		logic [NAME1_W-1:0] name1;
		logic [NAME2_W-1:0] name2;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		func_t  op;
		logic   ins_en;
		logic   del_en;
		entry_t item;
	} cmd_t;

endpackage

FILE: rtl/core/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell: one slot of the sorted record table
// Holds one record, compares its key with the broadcast key and, on an
// update, keeps its record, takes the new one or takes a neighbor's record.
// ----------------------------------------------------------------------------
module srt_cell import srt_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  logic [CNT_W-1:0] count,
	input  cmd_t             cmd,
	input  entry_t           left_entry,
	input  logic             left_flag,
	input  entry_t           right_entry,
	output entry_t           entry,
	output logic             flag,
	output logic             hit
);

	entry_t entry_q;
	logic   valid;
	logic   key_ge;
	logic   key_gt;

	// slot holds a live record when below the fill count
	assign valid  = CNT_W'(idx) < count;
	assign key_ge = $signed(entry_q.key) >= $signed(cmd.item.key);
	assign key_gt = $signed(entry_q.key) >  $signed(cmd.item.key);
	assign hit    = valid && (entry_q.key == cmd.item.key);
	assign entry  = entry_q;

	// position flag: set from the insert or delete point onward
	always_comb begin
		if (cmd.op == FUNC_INSERT) begin
			// first slot places an equal key behind itself
			flag = !valid || ((idx == '0) ? key_gt : key_ge);
		end else begin
			flag = valid && key_ge;
		end
	end

	// record update
	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (left_flag) begin
				entry_q <= left_entry;
			end else if (flag) begin
				entry_q <= cmd.item;
			end
		end else if (cmd.del_en && flag) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: rtl/core/srt_chain.sv
// ----------------------------------------------------------------------------
// srt_chain: row of record cells
// Links each cell to its neighbors and gathers the key match of all slots.
// ----------------------------------------------------------------------------
module srt_chain import srt_pkg::*; (
	input  logic             clk,
	input  logic [CNT_W-1:0] count,
	input  cmd_t             cmd,
	output logic             found
);

	entry_t entries [CAPACITY];
	logic   flags   [CAPACITY];
	logic   hits    [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_entry;
		logic   left_flag;
		entry_t right_entry;

		if (i == 0) begin : g_first
			assign left_entry = entries[0];
			assign left_flag  = 1'b0;
		end else begin : g_mid
			assign left_entry = entries[i-1];
			assign left_flag  = flags[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entries[i];
		end else begin : g_inner
			assign right_entry = entries[i+1];
		end

		srt_cell u_cell (
			.clk         (clk),
			.idx         (IDX_W'(i)),
			.count       (count),
			.cmd         (cmd),
			.left_entry  (left_entry),
			.left_flag   (left_flag),
			.right_entry (right_entry),
			.entry       (entries[i]),
			.flag        (flags[i]),
			.hit         (hits[i])
		);

		assign hit_vec[i] = hits[i];
	end

	// any live slot holds the key
	assign found = |hit_vec;

endmodule

FILE: rtl/core/sorted_record_table_core.sv
// ----------------------------------------------------------------------------
// sorted_record_table_core: bounded table of records in ascending key order
// Insert and delete of keyed records with a 20-byte name payload.
// ----------------------------------------------------------------------------
// Each input word is an insert (tuser 0) or a delete (tuser 1) and returns one
// output word with a status and the record count after the operation. An
// item is first captured from the input; then every cell of the record row
// compares its key with the broadcast key and shifts, inserts or holds at
// once, so the time does not depend on how full the table is. The next
// word is taken after that update; a finished result waits in the output
// register, and an update stalls only while that register is still full.
// Stored records have no reset; the count, state and output valid are cleared.
module sorted_record_table_core import srt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // key, name_word0, name_word1, name_word2
	input  logic                 s_tuser,  // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // status, entry_count
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                state_q;
	func_t                 op_q;
	entry_t                item_q;
	logic [CNT_W-1:0]      count_q;
	logic                  m_tvalid_q;
	status_t               status_q;
	logic [ECOUNT_W-1:0]   ecount_q;

	logic                  go;
	logic                  found;
	logic                  is_full;
	logic                  ins_en;
	logic                  del_en;
	status_t               status_nxt;
	logic [CNT_W-1:0]      count_nxt;
	cmd_t                  cmd;

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - STATUS_W - ECOUNT_W){1'b0}}, ecount_q, status_q};
	assign go       = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);

	// operation decode
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign ins_en  = go && (op_q == FUNC_INSERT) && !is_full;
	assign del_en  = go && (op_q == FUNC_DELETE) && found;

	always_comb begin
		status_nxt = STATUS_INSERTED;
		count_nxt  = count_q;
		case (op_q)
			FUNC_INSERT: begin
				if (is_full) begin
					status_nxt = STATUS_FULL;
				end else begin
					status_nxt = STATUS_INSERTED;
					count_nxt  = count_q + 1'b1;
				end
			end
			FUNC_DELETE: begin
				if (count_q == '0) begin
					status_nxt = STATUS_EMPTY;
				end else if (!found) begin
					status_nxt = STATUS_NOMATCH;
				end else begin
					status_nxt = STATUS_DELETED;
					count_nxt  = count_q - 1'b1;
				end
			end
			default: begin
				status_nxt = STATUS_INSERTED;
			end
		endcase
	end

	// broadcast to the cell row
	assign cmd.op     = op_q;
	assign cmd.ins_en = ins_en;
	assign cmd.del_en = del_en;
	assign cmd.item   = item_q;

	srt_chain u_chain (
		.clk   (clk),
		.count (count_q),
		.cmd   (cmd),
		.found (found)
	);

	// input capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q         <= func_t'(s_tuser);
			item_q.key   <= s_tdata[KEY_W-1:0];
			item_q.name0 <= s_tdata[KEY_W +: NAME0_W];
			item_q.name1 <= s_tdata[KEY_W+NAME0_W +: NAME1_W];
			item_q.name2 <= s_tdata[KEY_W+NAME0_W+NAME1_W +: NAME2_W];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= status_nxt;
			ecount_q <= ECOUNT_W'(count_nxt);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (go) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
